// ===== rtl/core/rcu_gp_pkg.sv =====
// Shared types and constants for the RCU grace-period tracker.
package rcu_gp_pkg;

  localparam int GEN_WIDTH = 64;
  localparam int DONE_WIDTH = 16;

  localparam logic [7:0]  ONLINE_CPUS_RESET = 8'd255;
  localparam logic [15:0] BATCH_LIMIT_RESET = 16'd10000;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_QUERY   = 2'd1,
    OP_WORK    = 2'd2,
    OP_NONE    = 2'd3
  } rcu_gp_op_t;

  typedef enum logic {
    REG_ONLINE_CPUS = 1'b0,
    REG_BATCH_LIMIT = 1'b1
  } rcu_gp_reg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] cpu;
  } rcu_gp_in_t;

  typedef struct packed {
    logic                  raise_request;
    logic                  resched_request;
    logic [DONE_WIDTH-1:0] callbacks_done;
    logic                  period_started;
    logic                  period_ended;
    logic [GEN_WIDTH-1:0]  global_generation;
  } rcu_gp_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic retire;
    logic start;
    logic commit;
  } rcu_gp_cmd_t;

endpackage

// ===== rtl/core/rcu_gp_stream_if.sv =====
// Valid/ready stream channel carrying one payload type.
interface rcu_gp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/rcu_gp_ram.sv =====
// Generic single-port-write, registered-read RAM.
module rcu_gp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/rcu_gp_ctrl.sv =====
// Sequencer: steps one transaction through retire, start and acknowledge.
module rcu_gp_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output rcu_gp_pkg::rcu_gp_cmd_t   cmd
);
  import rcu_gp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RETIRE,
    S_START,
    S_ACK
  } state_t;

  state_t state;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd.capture = req_valid && req_ready;
    cmd.retire  = (state == S_RETIRE);
    cmd.start   = (state == S_START);
    // result slot must be free (or emptying) before commit
    cmd.commit  = (state == S_ACK) && (!rsp_valid || rsp_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.capture) state <= S_RETIRE;
        end
        S_RETIRE: state <= S_START;
        S_START:  state <= S_ACK;
        S_ACK: begin
          if (cmd.commit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/rcu_gp_dp.sv =====
// Datapath: global generation state, per-CPU entry RAM and result register.
module rcu_gp_dp #(
  parameter int NCPU = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rcu_gp_pkg::rcu_gp_cmd_t  cmd,
  input  rcu_gp_pkg::rcu_gp_in_t   in_item,
  input  logic [7:0]               online_cpus,
  input  logic [15:0]              batch_limit,
  output rcu_gp_pkg::rcu_gp_out_t  out_item
);
  import rcu_gp_pkg::*;

  localparam int AW = (NCPU > 1) ? $clog2(NCPU) : 1;
  localparam int CW = COUNT_WIDTH;
  localparam int EW = GEN_WIDTH + 2 * CW;
  localparam int OW = (NCPU > 8) ? NCPU : 8;

  // global state
  logic [GEN_WIDTH-1:0] current_gen;
  logic [GEN_WIDTH-1:0] max_gen;
  logic [NCPU-1:0]      pending;
  logic [NCPU-1:0]      entry_valid;

  // captured transaction
  logic [1:0]    op_q;
  logic [AW-1:0] addr_q;
  logic          in_range_q;
  logic          seen_q;

  // working copy of the entry
  logic [GEN_WIDTH-1:0]  gen_q;
  logic [CW-1:0]         cur_q;
  logic [CW-1:0]         next_q;
  logic [DONE_WIDTH-1:0] done_q;
  logic                  splice_q;
  logic                  raise_q;
  logic                  resched_q;
  logic                  started_q;
  logic [GEN_WIDTH-1:0]  gen_inc_q;

  // input decode
  logic [AW+2:0] cpu_wide;
  logic [AW-1:0] cpu_addr;
  logic          in_range_now;

  assign cpu_wide     = (AW + 3)'(in_item.cpu);
  assign cpu_addr     = cpu_wide[AW-1:0];
  assign in_range_now = (7'(in_item.cpu) < 7'(NCPU));

  // entry RAM
  logic [EW-1:0] rd_data;
  logic [EW-1:0] wr_data;
  logic          wr_en;

  rcu_gp_ram #(
    .WIDTH (EW),
    .DEPTH (NCPU)
  ) u_entry_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr_q),
    .wdata (wr_data),
    .re    (cmd.capture),
    .raddr (cpu_addr),
    .rdata (rd_data)
  );

  logic [GEN_WIDTH-1:0] e_gen;
  logic [CW-1:0]        e_cur;
  logic [CW-1:0]        e_next;

  // never-written entries read as zero
  assign e_gen  = seen_q ? rd_data[EW-1 -: GEN_WIDTH] : '0;
  assign e_cur  = seen_q ? rd_data[2*CW-1 -: CW] : '0;
  assign e_next = seen_q ? rd_data[CW-1:0] : '0;

  logic is_enq, is_query, is_work;
  assign is_enq   = in_range_q && (op_q == OP_ENQUEUE);
  assign is_query = in_range_q && (op_q == OP_QUERY);
  assign is_work  = in_range_q && (op_q == OP_WORK);

  logic [OW-1:0]   online_ext;
  logic [NCPU-1:0] online_mask;
  logic [NCPU-1:0] cpu_bit;
  logic            pending_bit;

  assign online_ext  = OW'(online_cpus);
  assign online_mask = online_ext[NCPU-1:0];
  assign cpu_bit     = NCPU'(1) << addr_q;
  assign pending_bit = in_range_q && pending[addr_q];

  // retire step
  logic [CW-1:0] lim_ext;
  logic          ripe;
  logic [CW-1:0] retire_amt;
  logic [CW-1:0] done_full;
  logic [CW-1:0] cur1;
  logic [CW-1:0] next_sat;
  logic          splice_now;
  logic          raise_now;
  logic          resched_now;

  always_comb begin
    lim_ext     = CW'(batch_limit);
    ripe        = (current_gen > e_gen) && (e_cur != '0);
    retire_amt  = (e_cur > lim_ext) ? lim_ext : e_cur;
    done_full   = (is_work && ripe) ? retire_amt : '0;
    cur1        = e_cur - done_full;
    splice_now  = is_work && (cur1 == '0) && (e_next != '0);
    next_sat    = (e_next == '1) ? e_next : e_next + CW'(1);
    raise_now   = is_query && (ripe || ((e_cur == '0) && (e_next != '0)) || pending_bit);
    resched_now = is_enq && (next_sat >= lim_ext);
  end

  // start step
  logic [GEN_WIDTH-1:0] gen_inc;
  logic [GEN_WIDTH-1:0] max1;
  logic                 start_ok;

  always_comb begin
    gen_inc  = current_gen + GEN_WIDTH'(1);
    max1     = (max_gen < gen_inc) ? gen_inc : max_gen;
    start_ok = splice_q && !(current_gen > max1) && (pending == '0);
  end

  // acknowledge step
  logic            ack_hit;
  logic [NCPU-1:0] mask_after;
  logic            ended;
  logic            restart;

  always_comb begin
    ack_hit    = is_work && pending_bit;
    mask_after = pending & ~cpu_bit;
    ended      = ack_hit && (mask_after == '0);
    restart    = ended && !(gen_inc_q > max_gen);
    wr_en      = cmd.commit && (is_enq || is_work);
    wr_data    = {gen_q, cur_q, next_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_gen <= '0;
      max_gen     <= '0;
      pending     <= '0;
      entry_valid <= '0;
    end else begin
      if (cmd.start && splice_q) begin
        max_gen <= max1;
        if (start_ok) pending <= online_mask;
      end
      if (cmd.commit) begin
        if (ack_hit) pending <= restart ? online_mask : mask_after;
        if (ended) current_gen <= gen_inc_q;
        if (wr_en) entry_valid[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q       <= in_item.op;
      addr_q     <= cpu_addr;
      in_range_q <= in_range_now;
      seen_q     <= in_range_now && entry_valid[cpu_addr];
    end
    if (cmd.retire) begin
      gen_q     <= e_gen;
      cur_q     <= cur1;
      next_q    <= is_enq ? next_sat : e_next;
      done_q    <= done_full[DONE_WIDTH-1:0];
      splice_q  <= splice_now;
      raise_q   <= raise_now;
      resched_q <= resched_now;
    end
    if (cmd.start) begin
      gen_inc_q <= gen_inc;
      started_q <= start_ok;
      if (splice_q) begin
        // current is empty here, so the splice cannot overflow
        cur_q  <= next_q;
        next_q <= '0;
        gen_q  <= gen_inc;
      end
    end
    if (cmd.commit) begin
      out_item.raise_request     <= raise_q;
      out_item.resched_request   <= resched_q;
      out_item.callbacks_done    <= done_q;
      out_item.period_started    <= started_q || restart;
      out_item.period_ended      <= ended;
      out_item.global_generation <= ended ? gen_inc_q : current_gen;
    end
  end

endmodule

// ===== rtl/core/rcu_grace_period_tracker.sv =====
// Top level of the RCU grace-period tracker: config registers, sequencer, datapath.
//
//   channel  dir  handshake              payload
//   req      in   valid / ready          op, cpu
//   rsp      out  valid / ready          raise_request .. global_generation
//   apb      in   psel/penable/pwrite    online_cpus @0x0, batch_limit @0x4
//
// A transaction steps through accept with the entry RAM read, retire, grace-period
// start and acknowledge. The result is committed in the acknowledge step and shows
// on rsp the cycle after; the next request is taken once the sequencer is idle.
// The per-CPU entry RAM read and the 64-bit generation compares fix that sequence.
// Synchronous reset clears generations, the pending mask and the entry valid
// bits; no clearing pass is needed.
// A stalled rsp holds the block in the acknowledge step; the next request is
// taken while a finished result still waits.
module rcu_grace_period_tracker #(
  parameter int NCPU = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  rcu_gp_stream_if.sink      req,
  rcu_gp_stream_if.source    rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rcu_gp_pkg::*;

  // configuration registers
  logic [7:0]  online_cpus;
  logic [15:0] batch_limit;
  logic        cfg_write;
  rcu_gp_reg_t cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = rcu_gp_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      online_cpus <= ONLINE_CPUS_RESET;
      batch_limit <= BATCH_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_ONLINE_CPUS: online_cpus <= pwdata[7:0];
        REG_BATCH_LIMIT: batch_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_ONLINE_CPUS: prdata = 32'(online_cpus);
      REG_BATCH_LIMIT: prdata = 32'(batch_limit);
      default:         prdata = '0;
    endcase
  end

  // sequencer and datapath
  rcu_gp_cmd_t cmd;
  rcu_gp_in_t  in_item;
  rcu_gp_out_t out_item;

  assign in_item     = req.payload;
  assign rsp.payload = out_item;

  rcu_gp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  rcu_gp_dp #(
    .NCPU        (NCPU),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_item     (in_item),
    .online_cpus (online_cpus),
    .batch_limit (batch_limit),
    .out_item    (out_item)
  );

endmodule

// ===== rtl/core/rcu_gp_checker.sv =====
// Port-level checks for the grace-period tracker, bound to the top level.
module rcu_gp_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    req_valid,
  input logic                    req_ready,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input rcu_gp_pkg::rcu_gp_out_t rsp_payload
);
  import rcu_gp_pkg::*;

  // reset leaves the block empty and ready for a transaction
  assert property (@(posedge clk) rst |=> (!rsp_valid && req_ready))
    else $error("not idle after reset");

  // one transaction in flight at a time
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while busy");

  // a fresh result only appears after a busy cycle
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("result without a transaction");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
    else $error("stalled result changed");

endmodule

bind rcu_grace_period_tracker rcu_gp_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

// ===== bench/rcu_gp_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the RCU grace-period tracker: predicts each response and checks it.
module rcu_gp_scoreboard (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  input  logic                    req_ready,
  input  rcu_gp_pkg::rcu_gp_in_t  req_data,
  input  logic                    rsp_valid,
  input  logic                    rsp_ready,
  input  rcu_gp_pkg::rcu_gp_out_t rsp_data,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic                    pready,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output int unsigned             fails,
  output int unsigned             waiting,
  output int unsigned             checked,
  output int unsigned             periods_ended
);
  import rcu_gp_pkg::*;

  localparam int CPUS = 8;

  // mirrored tracker state
  logic [63:0] cur_gen;
  logic [63:0] max_gen;
  logic [7:0]  pending;
  logic [63:0] cpu_gen  [CPUS];
  logic [31:0] cur_cnt  [CPUS];
  logic [31:0] next_cnt [CPUS];
  logic [7:0]  online;
  logic [15:0] batch;

  rcu_gp_out_t expected_results [$];
  rcu_gp_out_t want;
  int unsigned fail_count  = 0;
  int unsigned check_count = 0;
  int unsigned end_count   = 0;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic logic has_ripe(int c);
    return cur_gen > cpu_gen[c] && cur_cnt[c] != 0;
  endfunction

  function automatic logic can_splice(int c);
    return cur_cnt[c] == 0 && next_cnt[c] != 0;
  endfunction

  // raise max_gen, then load the pending mask if no period is open
  function automatic logic try_start(logic [63:0] wanted);
    if (max_gen < wanted)
      max_gen = wanted;
    if (cur_gen > max_gen || pending != 0)
      return 1'b0;
    pending = online;
    return 1'b1;
  endfunction

  function automatic rcu_gp_out_t advance_tracker(rcu_gp_in_t ev);
    rcu_gp_out_t r;
    logic [31:0] take;
    int c;
    r = '0;
    c = ev.cpu;
    if (c < CPUS) begin
      case (rcu_gp_op_t'(ev.op))
        OP_ENQUEUE: begin
          next_cnt[c] = sat_add(next_cnt[c], 32'd1);
          r.resched_request = next_cnt[c] >= {16'd0, batch};
        end
        OP_QUERY: r.raise_request = has_ripe(c) || can_splice(c) || pending[c];
        OP_WORK: begin
          if (has_ripe(c)) begin
            take = (cur_cnt[c] > {16'd0, batch}) ? {16'd0, batch} : cur_cnt[c];
            cur_cnt[c] -= take;
            r.callbacks_done = take[15:0];
          end
          if (can_splice(c)) begin
            cur_cnt[c]  = sat_add(cur_cnt[c], next_cnt[c]);
            next_cnt[c] = '0;
            cpu_gen[c]  = cur_gen + 64'd1;
            if (try_start(cpu_gen[c]))
              r.period_started = 1'b1;
          end
          if (pending[c]) begin
            pending[c] = 1'b0;
            if (pending == 0) begin
              r.period_ended = 1'b1;
              cur_gen += 64'd1;
              if (try_start(max_gen))
                r.period_started = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    r.global_generation = cur_gen;
    return r;
  endfunction

  task automatic report(string what);
    fail_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_gen = '0;
      max_gen = '0;
      pending = '0;
      for (int i = 0; i < CPUS; i++) begin
        cpu_gen[i]  = '0;
        cur_cnt[i]  = '0;
        next_cnt[i] = '0;
      end
      online = ONLINE_CPUS_RESET;
      batch  = BATCH_LIMIT_RESET;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (rcu_gp_reg_t'(paddr[2]))
          REG_ONLINE_CPUS: online = pwdata[7:0];
          REG_BATCH_LIMIT: batch  = pwdata[15:0];
          default: ;
        endcase
      end
      if (req_valid && req_ready) begin
        expected_results.push_back(advance_tracker(req_data));
        if (expected_results[$].period_ended)
          end_count++;
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_results.size() == 0) begin
          report($sformatf("response with none outstanding, generation %0d",
                           rsp_data.global_generation));
        end else begin
          want = expected_results.pop_front();
          check_count++;
          if (rsp_data.raise_request !== want.raise_request)
            report($sformatf("raise_request got %0d want %0d",
                             rsp_data.raise_request, want.raise_request));
          if (rsp_data.resched_request !== want.resched_request)
            report($sformatf("resched_request got %0d want %0d",
                             rsp_data.resched_request, want.resched_request));
          if (rsp_data.callbacks_done !== want.callbacks_done)
            report($sformatf("callbacks_done got %0d want %0d",
                             rsp_data.callbacks_done, want.callbacks_done));
          if (rsp_data.period_started !== want.period_started)
            report($sformatf("period_started got %0d want %0d",
                             rsp_data.period_started, want.period_started));
          if (rsp_data.period_ended !== want.period_ended)
            report($sformatf("period_ended got %0d want %0d",
                             rsp_data.period_ended, want.period_ended));
          if (rsp_data.global_generation !== want.global_generation)
            report($sformatf("global_generation got %0d want %0d",
                             rsp_data.global_generation, want.global_generation));
        end
      end
    end
    fails         <= fail_count;
    waiting       <= expected_results.size();
    checked       <= check_count;
    periods_ended <= end_count;
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the RCU grace-period tracker: clock, reset, stimulus and verdict.
module tb;
  import rcu_gp_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fails;
  int unsigned waiting;
  int unsigned checked;
  int unsigned periods_ended;

  // calm: both sides run flat out, no gaps and no back-pressure
  bit          calm = 1'b0;
  int unsigned items_sent = 0;

  rcu_gp_stream_if #(.T(rcu_gp_in_t))  req_ch ();
  rcu_gp_stream_if #(.T(rcu_gp_out_t)) rsp_ch ();

  rcu_grace_period_tracker dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // The checker sees every handshake and every register write; the top only drives.
  rcu_gp_scoreboard u_scoreboard (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_ch.valid),
    .req_ready     (req_ch.ready),
    .req_data      (req_ch.payload),
    .rsp_valid     (rsp_ch.valid),
    .rsp_ready     (rsp_ch.ready),
    .rsp_data      (rsp_ch.payload),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fails         (fails),
    .waiting       (waiting),
    .checked       (checked),
    .periods_ended (periods_ended)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Response back-pressure: about a quarter of cycles stalled, none while calm.
  always @(posedge clk) begin
    rsp_ch.ready <= calm || ($urandom_range(99) >= 26);
  end

  // Hard stop well beyond the slowest legal run (~1000 transactions even under
  // heavy stalling).
  initial begin
    #(5_000_000);
    $display("tb failed");
    $finish;
  end

  // One request transaction. Valid is left high after the handshake, so back-to-back
  // transactions never lower and raise it within one time step; a random gap drops it.
  task automatic send_event(rcu_gp_op_t op, logic [2:0] cpu);
    while (!calm && $urandom_range(99) < 26) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.payload.op   <= op;
    req_ch.payload.cpu  <= cpu;
    do @(posedge clk); while (!req_ch.ready);
    if (op != OP_NONE)
      items_sent++;
  endtask

  // APB write: setup cycle, then access; the register takes the value on the
  // edge where psel, penable, pwrite and pready are all high. psel and penable
  // then drop before the task returns, so a second write starts on a fresh edge.
  task automatic write_reg(rcu_gp_reg_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drain: every expected response back, then wait for the pipeline
  // (four stages deep) to settle before touching the registers.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (8) @(posedge clk);
  endtask

  // Mostly well-formed rounds: a burst of enqueues, then a work pass over the
  // online CPUs (occasionally skipping one, occasionally touching an offline one)
  // with queries mixed in, so grace periods actually close and callbacks ripen.
  // The rest is noise, including the unused opcode.
  task automatic random_phase(int unsigned target, logic [7:0] mask);
    int unsigned base;
    int unsigned n;
    logic [2:0]  c;
    bit          same;
    base = items_sent;
    while (items_sent - base < target) begin
      if ($urandom_range(99) < 65) begin
        n    = $urandom_range(12, 0);
        c    = 3'($urandom);
        same = 1'($urandom_range(1));
        repeat (n) send_event(OP_ENQUEUE, same ? c : 3'($urandom));
        c = 3'($urandom);
        repeat (8) begin
          if ((mask[c] && $urandom_range(19) != 0) || $urandom_range(3) == 0) begin
            if ($urandom_range(9) < 3)
              send_event(OP_QUERY, c);
            send_event(OP_WORK, c);
          end
          c = c + 3'd1;
        end
      end else begin
        repeat ($urandom_range(6, 1))
          send_event(rcu_gp_op_t'($urandom_range(3)), 3'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0]  masks  [8];
    logic [15:0] limits [8];

    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening at reset settings (all CPUs online, limit 10000).
    send_event(OP_QUERY, 3'd0);     // nothing pending anywhere
    send_event(OP_ENQUEUE, 3'd0);
    send_event(OP_ENQUEUE, 3'd7);
    send_event(OP_QUERY, 3'd0);     // next list waiting to be spliced
    send_event(OP_WORK, 3'd3);      // idle CPU: no effect
    send_event(OP_NONE, 3'd5);      // unused opcode
    send_event(OP_WORK, 3'd0);      // splice and open the first period
    send_event(OP_QUERY, 3'd5);     // owes a quiescent state
    // last acknowledgement closes the period and opens the next in one go
    for (int k = 1; k < 8; k++)
      send_event(OP_WORK, 3'(k));
    send_event(OP_QUERY, 3'd0);
    for (int k = 0; k < 8; k++)
      send_event(OP_WORK, 3'(k));
    send_event(OP_NONE, 3'd7);
    wait_idle();

    // Register settings per phase include empty mask with zero limit, full mask with
    // the largest limit, single CPU with limit one, a calm phase and random ones.
    masks  = '{8'h00, 8'hFF,     8'h01,  8'h5A,  8'h00, 8'hFF,  8'h00, 8'h80};
    limits = '{16'd0, 16'hFFFF, 16'd1,  16'd2,  16'd0, 16'd3,  16'd0, 16'd10000};
    masks[4]  = 8'($urandom);
    limits[4] = 16'($urandom_range(8, 1));
    masks[6]  = 8'($urandom);
    limits[6] = 16'($urandom);

    for (int p = 0; p < 8; p++) begin
      calm = (p == 3);
      write_reg(REG_ONLINE_CPUS, {24'd0, masks[p]});
      write_reg(REG_BATCH_LIMIT, {16'd0, limits[p]});
      random_phase(110, masks[p]);
      wait_idle();
    end

    $display("run covered %0d events over 8 register settings plus the directed opening",
             items_sent);
    $display("%0d responses checked, %0d grace periods completed", checked, periods_ended);
    if (fails == 0 && waiting == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
